>>> design/crdf_pkg.sv
// Shared constants, types and helpers of the CAN record deframer with frame queues.
package crdf_pkg;

  // Depth of each port queue; one slot stays free, so a queue holds QDEPTH-1 frames
  localparam int QDEPTH = 1024;
  localparam int QIDX_W = $clog2(QDEPTH);
  localparam int ADDR_W = $clog2(2 * QDEPTH);

  // Record layout
  localparam int RECORD_BYTES = 19;
  localparam logic [4:0] POS_STATUS  = 5'd4;
  localparam logic [4:0] POS_CONTROL = 5'd6;
  localparam logic [4:0] POS_IDENT   = 5'd7;
  localparam logic [4:0] POS_DATA    = 5'd11;
  localparam logic [4:0] POS_LAST    = 5'(RECORD_BYTES - 1);

  // Control byte bits
  localparam int CTRL_EXT_BIT  = 7;
  localparam int CTRL_REM_BIT  = 6;
  localparam int CTRL_PORT_BIT = 4;

  // Request kinds carried on in_tuser
  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_READ = 1'b1;

  typedef logic [QIDX_W-1:0] idx_t;
  typedef logic [ADDR_W-1:0] addr_t;

  // One stored frame
  typedef struct packed {
    logic [63:0] payload;
    logic [3:0]  length;
    logic        remote;
    logic        extended;
    logic [28:0] id;
    logic [31:0] timestamp;
  } entry_t;

  // Push request from the record assembler to the queues
  typedef struct packed {
    logic   valid;
    logic   port;
    entry_t entry;
  } push_t;

  // Advance a ring index with wrap at the queue depth
  function automatic idx_t ring_next(input idx_t v);
    ring_next = (v == idx_t'(QDEPTH - 1)) ? '0 : idx_t'(v + idx_t'(1));
  endfunction

  // Slot address of an index within a port's half of the store
  function automatic addr_t slot_addr(input logic port, input idx_t v);
    slot_addr = port ? addr_t'(QDEPTH + int'(v)) : addr_t'(v);
  endfunction

endpackage

>>> design/can_record_deframer_fifo.sv
// Top level of the CAN record deframer with two frame queues and stream handshake.
// Usage:
//   The in_ channel carries one request per transfer. in_tuser is the kind:
//   0 = a byte of the record stream (in_tdata[7:0], in_tlast marks the last
//   byte of a transfer), 1 = a read of the queue named by in_tdata[8].
//   Complete 19-byte records with status zero are decoded and pushed to the
//   queue chosen by control bit 0x10; a frame meeting a full queue is dropped.
//   Error records and partial records at the end of a transfer are discarded.
//   Each read gives one result on the out_ channel: out_tuser is 1 when a
//   frame was popped, 0 (with all data zero) when the queue was empty.
//   Stream bytes give no result.
//   Throughput: one request per cycle while the receiver does not stall. A read's
//   result passes through the registered store read and then the output register.
//   Stream bytes and pushes complete in the accepting cycle.
//   When the receiver stalls, the output register and the read stage fill
//   and in_tready drops until out_tready returns; nothing is lost.
//   Reset clears the record position, the queue pointers and the pipeline
//   valid flags; the frame store needs no clearing.
module can_record_deframer_fifo (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [15:0]  in_tdata,   // [7:0] stream_byte, [8] read_port, zero pad
  input  logic         in_tlast,   // transfer_end
  input  logic         in_tuser,   // req_type
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [135:0] out_tdata,  // [31:0] frame_timestamp, [60:32] frame_id,
                                   // [61] frame_extended, [62] frame_remote,
                                   // [66:63] frame_length, [130:67] frame_payload
  output logic         out_tuser   // frame_valid
);
  import crdf_pkg::*;

  push_t  push;
  entry_t rd_q_r;
  entry_t res_r;
  logic   hit_r;
  logic   in_acc, byte_en, pop_en;
  logic   s1_valid_r, s1_move;
  logic   out_valid_r, out_hit_r;

  // Handshake and request decode
  assign s1_move   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_move;
  assign in_acc    = in_tvalid && in_tready;
  assign byte_en   = in_acc && in_tuser == REQ_BYTE;
  assign pop_en    = in_acc && in_tuser == REQ_READ;

  crdf_gather u_gather (
    .clk     (clk),
    .rst_n   (rst_n),
    .byte_en (byte_en),
    .byte_in (in_tdata[7:0]),
    .last_in (in_tlast),
    .push    (push)
  );

  crdf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .pop_en   (pop_en),
    .pop_port (in_tdata[8]),
    .hit_r    (hit_r),
    .rd_q_r   (rd_q_r)
  );

  // Track the read stage and the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop_en) s1_valid_r <= 1'b1;
      else if (s1_move) s1_valid_r <= 1'b0;
      if (s1_move) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // Load the result, zeroing the fields of an empty read
  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_hit_r <= hit_r;
      res_r     <= hit_r ? rd_q_r : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_hit_r;
  assign out_tdata  = {5'd0, res_r.payload, res_r.length, res_r.remote,
                       res_r.extended, res_r.id, res_r.timestamp};

endmodule

>>> design/crdf_gather.sv
// Record assembler: collects stream bytes into record fields and issues frame pushes.
module crdf_gather (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          byte_en,
  input  logic [7:0]    byte_in,
  input  logic          last_in,
  output crdf_pkg::push_t push
);
  import crdf_pkg::*;

  logic [4:0]  pos_r, pos_nxt, pos_eff;
  logic [31:0] ts_r, ts_nxt;
  logic [7:0]  status_r, status_nxt;
  logic [7:0]  ctrl_r, ctrl_nxt;
  logic [31:0] ident_r, ident_nxt;
  logic [63:0] data_r, data_nxt;
  logic        ext;

  // Merge the incoming byte into the field its position selects
  always_comb begin
    pos_eff    = (pos_r >= 5'(RECORD_BYTES)) ? 5'd0 : pos_r;
    ts_nxt     = ts_r;
    status_nxt = status_r;
    ctrl_nxt   = ctrl_r;
    ident_nxt  = ident_r;
    data_nxt   = data_r;
    for (int i = 0; i < 4; i++) begin
      if (pos_eff == 5'(i)) ts_nxt[8*i +: 8] = byte_in;
      if (pos_eff == 5'(int'(POS_IDENT) + i)) ident_nxt[8*i +: 8] = byte_in;
    end
    for (int i = 0; i < 8; i++) begin
      if (pos_eff == 5'(int'(POS_DATA) + i)) data_nxt[8*i +: 8] = byte_in;
    end
    if (pos_eff == POS_STATUS) status_nxt = byte_in;
    if (pos_eff == POS_CONTROL) ctrl_nxt = byte_in;
    if (last_in || pos_eff == POS_LAST) pos_nxt = 5'd0;
    else pos_nxt = 5'(pos_eff + 5'd1);
  end

  // Build the push for a record completed with clean status
  always_comb begin
    ext                  = ctrl_r[CTRL_EXT_BIT];
    push.valid           = byte_en && pos_eff == POS_LAST && status_r == 8'd0;
    push.port            = ctrl_r[CTRL_PORT_BIT];
    push.entry.timestamp = ts_r;
    push.entry.id        = ext ? ident_r[31:3] : {2'b00, ident_r[31:5]};
    push.entry.extended  = ext;
    push.entry.remote    = ctrl_r[CTRL_REM_BIT];
    push.entry.length    = ctrl_r[3:0];
    push.entry.payload   = data_nxt;
  end

  // Clear position under reset; field registers need none
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= 5'd0;
    end else if (byte_en) begin
      pos_r <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_en) begin
      ts_r     <= ts_nxt;
      status_r <= status_nxt;
      ctrl_r   <= ctrl_nxt;
      ident_r  <= ident_nxt;
      data_r   <= data_nxt;
    end
  end

endmodule

>>> design/crdf_queue.sv
// Two ring queues of frames in one shared store, with registered read data.
module crdf_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  crdf_pkg::push_t  push,
  input  logic             pop_en,
  input  logic             pop_port,
  output logic             hit_r,
  output crdf_pkg::entry_t rd_q_r
);
  import crdf_pkg::*;

  entry_t mem [2*QDEPTH];
  idx_t   wr_idx_r [2];
  idx_t   rd_idx_r [2];
  idx_t   wr_cur, wr_next, rd_cur;
  logic   full, empty, wr_en, rd_en;

  // Full when the write index would meet the read index; empty when they match
  always_comb begin
    wr_cur  = wr_idx_r[push.port];
    wr_next = ring_next(wr_cur);
    full    = (wr_next == rd_idx_r[push.port]);
    wr_en   = push.valid && !full;
    rd_cur  = rd_idx_r[pop_port];
    empty   = (rd_cur == wr_idx_r[pop_port]);
    rd_en   = pop_en && !empty;
  end

  // Advance the ring pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r[0] <= '0;
      wr_idx_r[1] <= '0;
      rd_idx_r[0] <= '0;
      rd_idx_r[1] <= '0;
      hit_r       <= 1'b0;
    end else begin
      if (wr_en) wr_idx_r[push.port] <= wr_next;
      if (rd_en) rd_idx_r[pop_port] <= ring_next(rd_cur);
      if (pop_en) hit_r <= !empty;
    end
  end

  // Store write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) mem[slot_addr(push.port, wr_cur)] <= push.entry;
    if (rd_en) rd_q_r <= mem[slot_addr(pop_port, rd_cur)];
  end

endmodule

>>> tb/can_record_deframer_fifo_check.sv
// Checker that predicts each read result of the CAN record deframer and compares it.
`timescale 1ns / 1ps

module can_record_deframer_fifo_check (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [15:0]  in_tdata,    // [7:0] stream byte, [8] read port, zero pad
  input  logic         in_tlast,    // transfer end
  input  logic         in_tuser,    // request kind
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [135:0] out_tdata,   // [31:0] timestamp, [60:32] id, [61] extended,
                                    // [62] remote, [66:63] length, [130:67] payload
  input  logic         out_tuser,   // frame popped
  output int           errors,
  output int           outstanding
);
  import crdf_pkg::*;

  // Record layout as seen on the wire
  localparam int RECORD_LEN  = 19;
  localparam int BYTE_STATUS = 4;
  localparam int BYTE_CTRL   = 6;
  localparam int BYTE_IDENT  = 7;
  localparam int BYTE_DATA   = 11;
  localparam int EXT_BIT     = 7;
  localparam int REMOTE_BIT  = 6;
  localparam int PORT_BIT    = 4;

  typedef struct packed {
    logic [63:0] payload;
    logic [3:0]  length;
    logic        remote;
    logic        extended;
    logic [28:0] id;
    logic [31:0] stamp;
  } frame_t;

  typedef struct packed {
    logic   hit;
    frame_t frame;
  } read_result_t;

  // Record being gathered
  logic [4:0]   rec_pos;
  logic [31:0]  rec_time;
  logic [7:0]   rec_status;
  logic [7:0]   rec_ctrl;
  logic [31:0]  rec_ident;
  logic [63:0]  rec_data;

  // Two frame rings, one slot of each kept free
  frame_t       ring [2][QDEPTH];
  int unsigned  wr_ptr [2];
  int unsigned  rd_ptr [2];

  read_result_t reads_due [$];
  int           shown;

  function automatic int unsigned wrap_inc(input int unsigned v);
    return (v == QDEPTH - 1) ? 0 : v + 1;
  endfunction

  // Decode the finished record and file it, drop it if its ring is full
  task automatic file_frame();
    logic   port;
    frame_t f;
    port = rec_ctrl[PORT_BIT];
    if (wrap_inc(wr_ptr[port]) == rd_ptr[port]) return;
    f.stamp    = rec_time;
    f.extended = rec_ctrl[EXT_BIT];
    f.remote   = rec_ctrl[REMOTE_BIT];
    f.length   = rec_ctrl[3:0];
    f.id       = rec_ctrl[EXT_BIT] ? 29'(rec_ident >> 3) : 29'(rec_ident >> 5);
    f.payload  = rec_data;
    ring[port][wr_ptr[port]] = f;
    wr_ptr[port] = wrap_inc(wr_ptr[port]);
  endtask

  // Place one stream byte into the record, close the record on its last byte
  task automatic absorb_byte(input logic [7:0] b, input logic last);
    int pos;
    pos = (rec_pos >= RECORD_LEN) ? 0 : int'(rec_pos);
    if (pos < BYTE_STATUS) rec_time[8*pos +: 8] = b;
    else if (pos == BYTE_STATUS) rec_status = b;
    else if (pos == BYTE_CTRL) rec_ctrl = b;
    else if (pos >= BYTE_IDENT && pos < BYTE_DATA) rec_ident[8*(pos-BYTE_IDENT) +: 8] = b;
    else if (pos >= BYTE_DATA) rec_data[8*(pos-BYTE_DATA) +: 8] = b;
    if (pos == RECORD_LEN - 1) begin
      if (rec_status == 8'd0) file_frame();
      pos = 0;
    end else begin
      pos = pos + 1;
    end
    rec_pos = last ? 5'd0 : 5'(pos);
  endtask

  // Pop a frame from a ring; an empty ring gives an all-zero result
  function automatic read_result_t pop_frame(input logic port);
    read_result_t r;
    r = '0;
    if (rd_ptr[port] != wr_ptr[port]) begin
      r.hit   = 1'b1;
      r.frame = ring[port][rd_ptr[port]];
      rd_ptr[port] = wrap_inc(rd_ptr[port]);
    end
    return r;
  endfunction

  // Compare one delivered result against the oldest read waiting
  task automatic compare_result();
    read_result_t want;
    frame_t       got;
    logic         ok;
    got = out_tdata[130:0];
    if (reads_due.size() == 0) begin
      errors++;
      if (shown < 10) begin
        shown++;
        $display("%0t: result with no read waiting, tuser=%b tdata=%h",
                 $time, out_tuser, out_tdata);
      end
      return;
    end
    want = reads_due.pop_front();
    ok = (out_tuser === want.hit) && (got.stamp === want.frame.stamp) &&
         (got.id === want.frame.id) && (got.extended === want.frame.extended) &&
         (got.remote === want.frame.remote) && (got.length === want.frame.length) &&
         (got.payload === want.frame.payload) && (out_tdata[135:131] === 5'd0);
    if (!ok) begin
      errors++;
      if (shown < 10) begin
        shown++;
        $display("%0t: read result mismatch", $time);
        $display("  expected valid=%b ts=%h id=%h ext=%b rem=%b len=%h data=%h pad=00",
                 want.hit, want.frame.stamp, want.frame.id, want.frame.extended,
                 want.frame.remote, want.frame.length, want.frame.payload);
        $display("  actual   valid=%b ts=%h id=%h ext=%b rem=%b len=%h data=%h pad=%h",
                 out_tuser, got.stamp, got.id, got.extended, got.remote, got.length,
                 got.payload, out_tdata[135:131]);
      end
    end
  endtask

  // Follow both channels: results first, so a new read never hides a missing one
  always @(posedge clk) begin : watch
    logic read_taken;
    logic result_taken;
    if (!rst_n) begin
      rec_pos     = '0;
      rec_time    = '0;
      rec_status  = '0;
      rec_ctrl    = '0;
      rec_ident   = '0;
      rec_data    = '0;
      wr_ptr      = '{0, 0};
      rd_ptr      = '{0, 0};
      reads_due.delete();
      errors      = 0;
      shown       = 0;
      outstanding <= 0;
    end else begin
      read_taken   = in_tvalid && in_tready && (in_tuser == REQ_READ);
      result_taken = out_tvalid && out_tready;
      if (result_taken) compare_result();
      if (in_tvalid && in_tready) begin
        if (in_tuser == REQ_READ) reads_due = {reads_due, pop_frame(in_tdata[8])};
        else absorb_byte(in_tdata[7:0], in_tlast);
      end
      outstanding <= outstanding + int'(read_taken) - int'(result_taken);
    end
  end

endmodule

>>> tb/can_record_deframer_fifo_test.sv
// Testbench top that drives byte and read requests into the deframer and gives the verdict.
`timescale 1ns / 1ps

module can_record_deframer_fifo_test;
  import crdf_pkg::*;

  localparam int PHASE_ITEMS = 400;
  localparam int HOLD_CYCLES = 300;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [15:0]  in_tdata = '0;
  logic         in_tlast = 1'b0;
  logic         in_tuser = REQ_BYTE;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [135:0] out_tdata;
  logic         out_tuser;
  int           errors;
  int           outstanding;
  int           send_idle = 30;
  int           recv_idle = 48;
  int           hold_requests = 0;
  int           sent = 0;

  can_record_deframer_fifo dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  can_record_deframer_fifo_check frame_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .errors      (errors),
    .outstanding (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offer one request after a random gap and hold it until taken
  task automatic offer(input logic kind, input logic [7:0] value, input logic last,
                       input logic port);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {7'd0, port, value};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    sent++;
  endtask

  task automatic send_byte(input logic [7:0] value, input logic last);
    offer(REQ_BYTE, value, last, 1'($urandom_range(1)));
  endtask

  // The byte and end fields of a read are noise
  task automatic send_read(input logic port);
    offer(REQ_READ, 8'($urandom), 1'($urandom_range(1)), port);
  endtask

  // Send the first count bytes of a record, with reads slipped in at random
  task automatic send_record(input logic [151:0] rec, input int count, input logic closes,
                             input int read_pct);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < read_pct) send_read(1'($urandom_range(1)));
      send_byte(rec[8*i +: 8], closes && (i == count - 1));
    end
  endtask

  // Record bytes from low to high: timestamp, status, spare, control, id, data
  function automatic logic [151:0] make_record(input logic [7:0] status,
                                               input logic [7:0] ctrl);
    return {$urandom, $urandom, $urandom, ctrl, 8'($urandom), status, $urandom};
  endfunction

  // One transfer: mostly whole records, sometimes errors, cut records or noise
  task automatic random_transfer();
    int         records;
    int         count;
    logic       last_rec;
    logic [7:0] status;
    records = $urandom_range(1, 3);
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 30)) send_byte(8'($urandom), $urandom_range(7) == 0);
      return;
    end
    for (int r = 0; r < records; r++) begin
      last_rec = (r == records - 1);
      status = ($urandom_range(7) == 0) ? 8'($urandom_range(1, 255)) : 8'd0;
      count = (last_rec && $urandom_range(7) == 0) ? $urandom_range(1, 18) : 19;
      send_record(make_record(status, 8'($urandom)), count,
                  last_rec && (count < 19 || $urandom_range(4) != 0), 3);
    end
    repeat ($urandom_range(0, 1)) send_read(1'($urandom_range(1)));
  endtask

  // Hold the sender until every read has its result
  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding > 0);
  endtask

  // Receiver: random stalls, plus a long hold-off on request
  initial begin : receiver
    int hold_left = 0;
    int served = 0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && served < hold_requests) begin
        hold_left = HOLD_CYCLES;
        served++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  initial begin : stimulus
    logic [151:0] rec;
    int           target;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty reads, an all-ones extended remote record on port 1, pop it, then empty again
    send_read(1'b0);
    send_read(1'b1);
    rec = '1;
    rec[39:32] = 8'd0;
    send_record(rec, 19, 1'b1, 0);
    send_read(1'b1);
    send_read(1'b1);

    // Sender sparse, receiver sparser
    target = sent + PHASE_ITEMS;
    while (sent < target) random_transfer();

    // Long receiver hold-off while reads keep coming, so the block backs up
    hold_requests <= hold_requests + 1;
    repeat (3) send_record(make_record(8'd0, 8'($urandom)), 19, 1'b1, 40);
    wait_for_results();

    // Swap the idling of the two sides
    send_idle = 48;
    recv_idle <= 30;
    target = sent + PHASE_ITEMS;
    while (sent < target) random_transfer();
    wait_for_results();

    // No idling at all
    send_idle = 0;
    recv_idle <= 0;
    target = sent + PHASE_ITEMS;
    while (sent < target) random_transfer();
    wait_for_results();

    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
